FILE: design/blm_pkg.sv
// ----------------------------------------------------------------------------
// Battery level monitor package
// Shared widths, register indexes, reset values and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package blm_pkg;

  // Field widths.
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RawW   = 10;
  localparam int unsigned MvW    = 14;
  localparam int unsigned PctW   = 7;
  localparam int unsigned GainW  = 22;
  localparam int unsigned IntvW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 22;

  // Number of ADC bits that are significant in a raw sample.
  localparam int unsigned AdcBits = 10;
  localparam logic [RawW-1:0] AdcMask = RawW'((64'd1 << AdcBits) - 64'd1);

  // Scaling arithmetic.
  localparam int unsigned ProdW   = GainW + RawW;
  localparam int unsigned GainFrac = 16;
  localparam int unsigned SumW    = ProdW - GainFrac + 1;
  localparam logic [MvW-1:0] MvMax    = MvW'(16383);
  localparam logic [MvW-1:0] MvOffset = MvW'(300);

  // Percentage arithmetic: numerator is 100 * (v - empty).
  localparam logic [PctW-1:0] PctFull = PctW'(100);
  localparam int unsigned NumW      = MvW + PctW;
  localparam int unsigned DivSteps  = PctW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  // Stream word widths, padded to whole bytes.
  localparam int unsigned InBits   = TimeW + RawW;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits  = MvW + PctW + 5;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgAdcGain     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFullMv      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEmptyMv     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgChargingMv  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNoBatteryMv = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLowBatteryMv = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgReadIntv    = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgZeroChg     = 3'd7;

  // Configuration reset values.
  localparam logic [GainW-1:0] RstAdcGain     = GainW'(422400);
  localparam logic [MvW-1:0]   RstFullMv      = MvW'(4200);
  localparam logic [MvW-1:0]   RstEmptyMv     = MvW'(3270);
  localparam logic [MvW-1:0]   RstChargingMv  = MvW'(4210);
  localparam logic [MvW-1:0]   RstNoBatteryMv = MvW'(2230);
  localparam logic [MvW-1:0]   RstLowBatteryMv = MvW'(3100);
  localparam logic [IntvW-1:0] RstReadIntv    = IntvW'(5000);

  // Configuration register bank.
  typedef struct packed {
    logic [GainW-1:0] adc_gain;
    logic [MvW-1:0]   full_mv;
    logic [MvW-1:0]   empty_mv;
    logic [MvW-1:0]   charging_mv;
    logic [MvW-1:0]   no_battery_mv;
    logic [MvW-1:0]   low_battery_mv;
    logic [IntvW-1:0] read_interval_ms;
    logic             zero_while_charging;
  } blm_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic check_time;
    logic mul;
    logic scale;
    logic classify;
    logic prep;
    logic div_step;
    logic load_out;
  } blm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fresh;
    logic need_div;
  } blm_sts_t;

endpackage

FILE: design/blm_cfg.sv
// ----------------------------------------------------------------------------
// Battery level monitor configuration registers
// Holds the eight settings, written one at a time through the write port.
// ----------------------------------------------------------------------------
module blm_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [blm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [blm_pkg::CfgDataW-1:0] cfg_data_i,
  output blm_pkg::blm_cfg_t        cfg_o
);
  import blm_pkg::*;

  blm_cfg_t cfg_q;

  // Register writes, decoded by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adc_gain            <= RstAdcGain;
      cfg_q.full_mv             <= RstFullMv;
      cfg_q.empty_mv            <= RstEmptyMv;
      cfg_q.charging_mv         <= RstChargingMv;
      cfg_q.no_battery_mv       <= RstNoBatteryMv;
      cfg_q.low_battery_mv      <= RstLowBatteryMv;
      cfg_q.read_interval_ms    <= RstReadIntv;
      cfg_q.zero_while_charging <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAdcGain:      cfg_q.adc_gain         <= cfg_data_i[GainW-1:0];
        CfgFullMv:       cfg_q.full_mv          <= cfg_data_i[MvW-1:0];
        CfgEmptyMv:      cfg_q.empty_mv         <= cfg_data_i[MvW-1:0];
        CfgChargingMv:   cfg_q.charging_mv      <= cfg_data_i[MvW-1:0];
        CfgNoBatteryMv:  cfg_q.no_battery_mv    <= cfg_data_i[MvW-1:0];
        CfgLowBatteryMv: cfg_q.low_battery_mv   <= cfg_data_i[MvW-1:0];
        CfgReadIntv:     cfg_q.read_interval_ms <= cfg_data_i[IntvW-1:0];
        CfgZeroChg:      cfg_q.zero_while_charging <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/blm_dp.sv
// ----------------------------------------------------------------------------
// Battery level monitor datapath
// Interval check, sample scaling, level classification and a seven-step
// restoring divider for the charge percentage, plus the output register.
// ----------------------------------------------------------------------------
module blm_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  blm_pkg::blm_cfg_t          cfg_i,
  input  blm_pkg::blm_cmd_t          cmd_i,
  output blm_pkg::blm_sts_t          sts_o,
  input  logic [blm_pkg::InDataW-1:0]  in_data_i,
  output logic [blm_pkg::OutDataW-1:0] out_data_o
);
  import blm_pkg::*;

  // Input word and item state.
  logic [TimeW-1:0] now_q;
  logic [RawW-1:0]  raw_q;
  logic             fresh_q;
  logic [ProdW-1:0] prod_q;
  logic [MvW-1:0]   held_q;
  logic [TimeW-1:0] last_q;
  logic             present_q, ext_q, low_q;
  logic [PctW-1:0]  pct_q;
  logic [NumW-1:0]  rem_q, dvs_q;
  logic [OutDataW-1:0] out_q;

  logic [TimeW-1:0] elapsed;
  logic             fresh;
  logic [SumW-1:0]  mv_sum;
  logic [MvW-1:0]   mv_sat;
  logic             present, ext, low, force_zero, at_full;
  logic [MvW-1:0]   span, above_empty;
  logic             div_ge;

  // Interval test on the wrapping millisecond difference.
  assign elapsed = now_q - last_q;
  assign fresh   = elapsed > TimeW'(cfg_i.read_interval_ms);

  // Scaled sample with offset, saturated to the voltage range.
  assign mv_sum = SumW'(prod_q[ProdW-1:GainFrac]) + SumW'(MvOffset);
  assign mv_sat = (mv_sum > SumW'(MvMax)) ? MvMax : mv_sum[MvW-1:0];

  // Level comparisons on the held voltage.
  assign present    = held_q >= cfg_i.no_battery_mv;
  assign ext        = held_q > cfg_i.charging_mv;
  assign low        = present && !ext && (held_q < cfg_i.low_battery_mv);
  assign force_zero = !present || (cfg_i.zero_while_charging && ext) ||
                      (held_q <= cfg_i.empty_mv);
  // At or above full the quotient is at least 100 and clamps there.
  assign at_full    = held_q >= cfg_i.full_mv;

  assign span        = cfg_i.full_mv - cfg_i.empty_mv;
  assign above_empty = held_q - cfg_i.empty_mv;
  assign div_ge      = rem_q >= dvs_q;

  assign sts_o.fresh    = fresh;
  assign sts_o.need_div = !force_zero && !at_full;

  // Control flags of the item in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      last_q  <= '0;
      fresh_q <= 1'b0;
    end else begin
      if (cmd_i.check_time) begin
        fresh_q <= fresh;
      end
      if (cmd_i.scale) begin
        held_q <= mv_sat;
        last_q <= now_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      now_q <= in_data_i[TimeW-1:0];
      raw_q <= in_data_i[TimeW +: RawW];
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(cfg_i.adc_gain) * ProdW'(raw_q & AdcMask);
    end
    if (cmd_i.classify) begin
      present_q <= present;
      ext_q     <= ext;
      low_q     <= low;
      pct_q     <= (!force_zero && at_full) ? PctFull : '0;
    end
    if (cmd_i.prep) begin
      rem_q <= NumW'(above_empty) * NumW'(PctFull);
      dvs_q <= NumW'({span, {(DivSteps - 1){1'b0}}});
    end
    // One quotient bit per step, most significant first.
    if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - dvs_q;
      end
      dvs_q <= dvs_q >> 1;
      pct_q <= {pct_q[PctW-2:0], div_ge};
    end
    if (cmd_i.load_out) begin
      out_q <= OutDataW'({fresh_q,
                          low_q,
                          present_q && ext_q,
                          ext_q,
                          present_q,
                          present_q ? pct_q : {PctW{1'b0}},
                          present_q ? held_q : {MvW{1'b0}}});
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: design/blm_ctrl.sv
// ----------------------------------------------------------------------------
// Battery level monitor controller
// Sequences one request through the datapath and runs both stream handshakes.
// ----------------------------------------------------------------------------
module blm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  blm_pkg::blm_sts_t sts_i,
  output blm_pkg::blm_cmd_t cmd_o
);
  import blm_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StTime,
    StMul,
    StScale,
    StClassify,
    StPrep,
    StDiv,
    StDone
  } state_e;

  state_e             state_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               in_ready_q, out_valid_q;
  logic               accept, out_free;

  assign accept   = in_valid_i && in_ready_q;
  assign out_free = !out_valid_q || out_ready_i;

  // Commands decoded from the current state.
  always_comb begin
    cmd_o            = '0;
    cmd_o.load_in    = accept;
    cmd_o.check_time = (state_q == StTime);
    cmd_o.mul        = (state_q == StMul);
    cmd_o.scale      = (state_q == StScale);
    cmd_o.classify   = (state_q == StClassify);
    cmd_o.prep       = (state_q == StPrep);
    cmd_o.div_step   = (state_q == StDiv);
    cmd_o.load_out   = (state_q == StDone) && out_free;
  end

  // State, step count and handshake flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      div_cnt_q   <= '0;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      // A new status word takes the output register as the old one leaves.
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            in_ready_q <= 1'b0;
            state_q    <= StTime;
          end
        end
        StTime: begin
          state_q <= sts_i.fresh ? StMul : StClassify;
        end
        StMul: begin
          state_q <= StScale;
        end
        StScale: begin
          state_q <= StClassify;
        end
        StClassify: begin
          state_q <= sts_i.need_div ? StPrep : StDone;
        end
        StPrep: begin
          div_cnt_q <= '0;
          state_q   <= StDiv;
        end
        StDiv: begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            in_ready_q  <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/battery_level_monitor.sv
// An accepted request passes the time check, the multiply and scale states when
// a new sample is taken, classification, the divider setup and steps when the
// percentage needs them (one quotient bit per cycle), and the output load. No
// new request is taken before that; the rate is bounded by the shared
// divider and single controller; a full output register holds the controller.
// Reset clears the held voltage and the last sample time and loads the defaults.
// ----------------------------------------------------------------------------
// Battery level monitor
// Turns timed ADC samples of the battery divider into voltage, presence,
// external power, charging, low-battery and charge percentage reports.
// ----------------------------------------------------------------------------
module battery_level_monitor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // Fields from bit 0: now_ms[31:0], raw_sample[41:32], zero padding.
  input  logic [blm_pkg::InDataW-1:0]  s_axis_tdata,
  // Status stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // Fields from bit 0: voltage_mv[13:0], percent[20:14], battery_present[21],
  // external_power[22], charging[23], low_battery[24], fresh_sample[25],
  // zero padding.
  output logic [blm_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [blm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [blm_pkg::CfgDataW-1:0] cfg_data_i
);
  import blm_pkg::*;

  blm_cfg_t cfg;
  blm_cmd_t cmd;
  blm_sts_t sts;

  blm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  blm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  blm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

FILE: design/blm_checker.sv
// ----------------------------------------------------------------------------
// Battery level monitor port checker
// Watches the status stream for consistent flags and a held word under stall.
// ----------------------------------------------------------------------------
module blm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [blm_pkg::OutDataW-1:0] m_axis_tdata
);
  import blm_pkg::*;

  // A stalled status word stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("status word changed while stalled");

  // The percentage never exceeds full charge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20:14] <= 7'd100)
    else $error("percentage above 100");

  // Charging is exactly presence together with external power.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23] == (m_axis_tdata[21] && m_axis_tdata[22]))
    else $error("charging flag inconsistent");

  // Without a battery the voltage, percentage and low flag read zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[21] |->
      m_axis_tdata[13:0] == 14'd0 && m_axis_tdata[20:14] == 7'd0 && !m_axis_tdata[24])
    else $error("no-battery report not cleared");

  // Low battery is only flagged on battery power.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[21] && !m_axis_tdata[22])
    else $error("low battery flagged on external power");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (.*);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Battery level monitor testbench
// Sends timed ADC requests over the request stream and checks every status
// word against a cycle-free predictor of the sampling, scaling, threshold and
// percentage logic. Directed requests cover the boundary cases, then register
// settings at their extremes, stalled random traffic and a full-rate run follow.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import blm_pkg::*;

  // One status word as it appears on the status stream, bit 0 last.
  typedef struct packed {
    logic            fresh;
    logic            low;
    logic            chg;
    logic            ext;
    logic            present;
    logic [PctW-1:0] pct;
    logic [MvW-1:0]  mv;
  } status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // Fields from bit 0: now_ms[31:0], raw_sample[41:32], zero padding.
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // Fields from bit 0: voltage_mv[13:0], percent[20:14], battery_present[21],
  // external_power[22], charging[23], low_battery[24], fresh_sample[25].
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Predictor state: register copy, held voltage and time of the last sample.
  blm_cfg_t      setup;
  logic [MvW-1:0] held_mv;
  logic [31:0]    last_sample_ms;

  status_t        pending_status[$];
  int unsigned    mismatch_count = 0;
  bit             idle_en = 1'b1;
  logic [31:0]    now_ms = '0;

  battery_level_monitor DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Charge estimate for a present battery.
  function automatic logic [PctW-1:0] percent_of_charge(logic [MvW-1:0] v);
    int unsigned span;
    int unsigned q;
    if (v <= setup.empty_mv) return '0;
    // Empty and full collapsed: step from 0 to full at the full level.
    if (setup.full_mv <= setup.empty_mv) return (v >= setup.full_mv) ? PctFull : '0;
    span = 32'(setup.full_mv) - 32'(setup.empty_mv);
    q = (32'd100 * (32'(v) - 32'(setup.empty_mv))) / span;
    return (q > 32'd100) ? PctFull : PctW'(q);
  endfunction

  // Expected status for one accepted request; updates the held sample.
  function automatic status_t predict_status(logic [31:0] now, logic [RawW-1:0] raw_in);
    status_t        s;
    logic [31:0]    elapsed;
    logic [63:0]    mv_wide;
    logic [RawW-1:0] raw;
    raw = raw_in & AdcMask;
    s = '0;
    elapsed = now - last_sample_ms;
    if (elapsed > 32'(setup.read_interval_ms)) begin
      last_sample_ms = now;
      mv_wide = ((64'(setup.adc_gain) * 64'(raw)) >> GainFrac) + 64'(MvOffset);
      held_mv = (mv_wide > 64'(MvMax)) ? MvMax : mv_wide[MvW-1:0];
      s.fresh = 1'b1;
    end
    s.present = held_mv >= setup.no_battery_mv;
    s.ext = held_mv > setup.charging_mv;
    s.chg = s.present && s.ext;
    s.low = s.present && !s.ext && (held_mv < setup.low_battery_mv);
    // Without a battery both voltage and percent read zero.
    if (s.present) begin
      s.mv = held_mv;
      if (!(setup.zero_while_charging && s.ext)) s.pct = percent_of_charge(held_mv);
    end
    return s;
  endfunction

  // Time step to the next request, biased around the read interval edge.
  function automatic logic [31:0] next_step();
    logic [31:0] intv;
    intv = 32'(setup.read_interval_ms);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, intv);
      4, 5, 6:    return intv + $urandom_range(0, 2);
      7:          return $urandom();
      default:    return $urandom_range(1, 100000);
    endcase
  endfunction

  // Send one request word and record its expected status on acceptance.
  task automatic send_request(logic [31:0] now, logic [RawW-1:0] raw);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({raw, now});
    do @(posedge clk_i); while (!s_axis_tready);
    pending_status.push_back(predict_status(now, raw));
  endtask

  // Stop sending and wait until every expected status word has arrived.
  task automatic drain_status();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  // Write one register and mirror it in the predictor.
  task automatic write_setting(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgAdcGain:      setup.adc_gain = value[GainW-1:0];
      CfgFullMv:       setup.full_mv = value[MvW-1:0];
      CfgEmptyMv:      setup.empty_mv = value[MvW-1:0];
      CfgChargingMv:   setup.charging_mv = value[MvW-1:0];
      CfgNoBatteryMv:  setup.no_battery_mv = value[MvW-1:0];
      CfgLowBatteryMv: setup.low_battery_mv = value[MvW-1:0];
      CfgReadIntv:     setup.read_interval_ms = value[IntvW-1:0];
      CfgZeroChg:      setup.zero_while_charging = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Load a whole register set once the block is idle.
  task automatic load_setup(int unsigned gain, int unsigned full, int unsigned empty,
                            int unsigned chg, int unsigned nobat, int unsigned low,
                            int unsigned intv, int unsigned zero);
    drain_status();
    write_setting(CfgAdcGain, CfgDataW'(gain));
    write_setting(CfgFullMv, CfgDataW'(full));
    write_setting(CfgEmptyMv, CfgDataW'(empty));
    write_setting(CfgChargingMv, CfgDataW'(chg));
    write_setting(CfgNoBatteryMv, CfgDataW'(nobat));
    write_setting(CfgLowBatteryMv, CfgDataW'(low));
    write_setting(CfgReadIntv, CfgDataW'(intv));
    write_setting(CfgZeroChg, CfgDataW'(zero));
  endtask

  // Random requests; the raw sample sits at an end of its range now and then.
  task automatic send_random(int unsigned count);
    logic [RawW-1:0] raw;
    repeat (count) begin
      now_ms = now_ms + next_step();
      case ($urandom_range(0, 9))
        0:       raw = '0;
        1:       raw = '1;
        default: raw = $urandom_range(0, 1023);
      endcase
      send_request(now_ms, raw);
    end
  endtask

  // Boundary requests under the reset register values.
  task automatic test_reset_defaults();
    send_request(32'd0, 10'd0);          // no time elapsed, held voltage zero
    send_request(32'd5000, 10'h3FF);     // exactly the interval: reused
    send_request(32'd5001, 10'h3FF);     // one past: sampled, charging
    send_request(32'd5002, 10'd0);
    send_request(32'd10001, 10'd0);
    send_request(32'd10002, 10'd0);      // offset only: no battery
    send_request(32'd15003, 10'd461);    // just above empty
    send_request(32'd20004, 10'd460);    // just below empty
    send_request(32'd25005, 10'd528);    // mid range
    send_request(32'd30006, 10'd388);    // low battery
    send_request(32'd30007, 10'h3FF);
    send_request(32'd35008, 10'd605);    // just under full
    send_request(32'd40009, 10'd606);    // above full, below charging
    send_request(32'd45010, 10'd607);    // above charging
    send_request(32'hFFFF_FFFF, 10'h2AA);
    send_request(32'h0000_1387, 10'h155); // wrapped difference equals interval
    send_request(32'h0000_1388, 10'h155); // wrapped difference one past
    send_request(32'hAAAA_AAAA, 10'h3FF);
    send_request(32'h5555_5555, 10'h200);
    send_request(32'h5555_5555, 10'h0FF);
    now_ms = 32'h5555_5555;
  endtask

  // Register extremes, each followed by a short random burst.
  task automatic test_register_extremes();
    // Zero gain and zero interval: every new millisecond samples 300 mV.
    load_setup(0, 4200, 3270, 4210, 2230, 3100, 0, 0);
    send_request(now_ms, 10'h3FF);
    send_request(now_ms, 10'h3FF);
    send_random(12);
    // Largest gain saturates; widest thresholds and longest interval.
    load_setup(4194303, 16383, 0, 16383, 0, 16383, 65535, 1);
    send_random(16);
    // Empty above full: percent steps at the full level.
    load_setup(422400, 3000, 3500, 5000, 1000, 2000, 50, 0);
    send_random(16);
    // Empty equal to full.
    load_setup(422400, 3500, 3500, 4500, 1000, 3300, 20, 1);
    send_random(16);
    // Battery never present but external power still reported.
    load_setup(1000000, 4200, 3270, 100, 16383, 3100, 10, 1);
    send_random(16);
    // Empty at the top: percent always zero.
    load_setup(4194303, 16383, 16383, 16383, 0, 0, 5, 0);
    send_random(16);
    // Charging level below full with the zero-while-charging mode off.
    load_setup(500000, 4200, 3270, 3000, 2230, 3100, 100, 0);
    send_random(16);
  endtask

  // Random register sets, mostly well-ordered thresholds.
  task automatic test_random_traffic();
    int unsigned empty;
    for (int phase = 0; phase < 6; phase++) begin
      idle_en = (phase != 2);
      empty = $urandom_range(2500, 3600);
      if ($urandom_range(0, 3) == 0) begin
        load_setup($urandom_range(0, 4194303), $urandom_range(0, 16383),
                   $urandom_range(0, 16383), $urandom_range(0, 16383),
                   $urandom_range(0, 16383), $urandom_range(0, 16383),
                   $urandom_range(0, 65535), $urandom_range(0, 1));
      end else begin
        load_setup($urandom_range(300000, 500000), empty + $urandom_range(1, 1200),
                   empty, $urandom_range(3800, 4600), $urandom_range(1500, 3000),
                   $urandom_range(2800, 3500), $urandom_range(0, 2000),
                   $urandom_range(0, 1));
      end
      send_random(170);
    end
    idle_en = 1'b1;
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_full_rate();
    load_setup(422400, 4200, 3270, 4210, 2230, 3100, 3, 1);
    idle_en = 1'b0;
    send_random(180);
  endtask

  // Ready side: random stall bursts while idling is enabled.
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each accepted status word with the oldest expectation.
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_status
    status_t want;
    status_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = status_t'(m_axis_tdata[$bits(status_t)-1:0]);
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected status word, expected none, actual %h", $time,
                 m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("voltage_mv", want.mv, got.mv);
        check_field("percent", want.pct, got.pct);
        check_field("battery_present", want.present, got.present);
        check_field("external_power", want.ext, got.ext);
        check_field("charging", want.chg, got.chg);
        check_field("low_battery", want.low, got.low);
        check_field("fresh_sample", want.fresh, got.fresh);
        check_field("padding", 0, m_axis_tdata[OutDataW-1:$bits(status_t)]);
      end
    end
  end

  // Main sequence.
  initial begin
    setup = '{adc_gain: RstAdcGain, full_mv: RstFullMv, empty_mv: RstEmptyMv,
              charging_mv: RstChargingMv, no_battery_mv: RstNoBatteryMv,
              low_battery_mv: RstLowBatteryMv, read_interval_ms: RstReadIntv,
              zero_while_charging: 1'b1};
    held_mv = '0;
    last_sample_ms = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_full_rate();
    drain_status();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
